[sv/stt_pkg.sv]
// Shared types, codes and byte-class helpers for the source text tokenizer.
package stt_pkg;

    // Line counter width (which sets its saturation limit) and result buffer depth
    localparam int LINE_COUNT_BITS = 24;
    localparam int MAX_RESULTS     = 4;

    // Character constants
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    // Result kinds
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_WARN  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Token classes
    localparam logic [1:0] CLS_WORD   = 2'd0;
    localparam logic [1:0] CLS_NUMBER = 2'd1;
    localparam logic [1:0] CLS_OP     = 2'd2;
    localparam logic [1:0] CLS_STRING = 2'd3;

    // Warning codes
    localparam logic [2:0] WARN_NONE     = 3'd0;
    localparam logic [2:0] WARN_ILLEGAL  = 3'd1;
    localparam logic [2:0] WARN_BANG     = 3'd2;
    localparam logic [2:0] WARN_STR_NL   = 3'd3;
    localparam logic [2:0] WARN_STR_BYTE = 3'd4;

    // One result item, without the line number and last mark
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [1:0] cls;
        logic       first;
        logic       last;
        logic [2:0] warn;
    } t_res;

    function automatic t_res mk_tok(input logic [7:0] ch, input logic [1:0] cls,
                                    input logic first, input logic last);
        t_res r;
        r.kind  = KIND_TOKEN;
        r.ch    = ch;
        r.cls   = cls;
        r.first = first;
        r.last  = last;
        r.warn  = WARN_NONE;
        return r;
    endfunction

    function automatic t_res mk_warn(input logic [2:0] warn);
        t_res r;
        r       = '0;
        r.kind  = KIND_WARN;
        r.warn  = warn;
        return r;
    endfunction

    function automatic t_res mk_end();
        t_res r;
        r       = '0;
        r.kind  = KIND_END;
        return r;
    endfunction

    // Byte classes
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Operators that may take a trailing '='
    function automatic logic is_pair_op(input logic [7:0] c);
        return c == 8'h3C || c == 8'h3E || c == CH_BANG || c == 8'h3A;
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        logic r;
        case (c)
            8'h3B, 8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h28, 8'h29,
            8'h3D, 8'h7B, 8'h7D, 8'h26, 8'h7C, 8'h5B, 8'h5D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Bytes allowed inside a string literal
    function automatic logic str_ok(input logic [7:0] c);
        logic r;
        case (c)
            8'h20, 8'h5F, 8'h2C, 8'h3B, 8'h3A, 8'h2E, 8'h27: r = 1'b1;
            default: r = is_letter(c) || is_digit(c);
        endcase
        return r;
    endfunction

endpackage

[sv/source_text_tokenizer_top.sv]
// Source text tokenizer: byte scanner with one byte of lookahead and a result buffer.
// Results of an item appear on the output in the cycle after it is accepted.
// Throughput: one item per cycle while each item yields at most one result and the
// output is not stalled; an item that yields several results (up to four) stalls the input
// until the single output port has drained the result buffer down to its last result.
// Reset (synchronous, active low): scanner idle, nothing held, line count one, buffer empty.
module source_text_tokenizer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_char_code,
    input  logic                             i_end_of_text,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_result_kind,
    output logic [7:0]                       o_token_char,
    output logic [1:0]                       o_token_class,
    output logic                             o_first_of_token,
    output logic                             o_last_of_token,
    output logic [2:0]                       o_warning_code,
    output logic [stt_pkg::LINE_COUNT_BITS-1:0] o_line_number,
    output logic                             o_last_result
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_INT,
        MODE_FRAC,
        MODE_SLASH,
        MODE_OP,
        MODE_STR,
        MODE_COMMENT
    } t_mode;

    localparam int CNT_W = $clog2(stt_pkg::MAX_RESULTS + 1);
    localparam int IDX_W = $clog2(stt_pkg::MAX_RESULTS);
    localparam logic [stt_pkg::LINE_COUNT_BITS-1:0] LINE_MAX = '1;

    // Scanner state
    t_mode                              r_mode, n_mode;
    logic [7:0]                         r_held, n_held;
    logic                               r_first, n_first;
    logic [stt_pkg::LINE_COUNT_BITS-1:0] r_line;
    logic                               n_line_inc;

    // Result buffer, drained from entry 0
    stt_pkg::t_res                      r_res [stt_pkg::MAX_RESULTS];
    logic [CNT_W-1:0]                   r_cnt;
    logic [stt_pkg::LINE_COUNT_BITS-1:0] r_out_line;

    stt_pkg::t_res                      n_res [stt_pkg::MAX_RESULTS];
    logic [CNT_W-1:0]                   n_cnt;

    logic take, pop, do_start;
    logic [7:0] c;

    assign c           = i_char_code;
    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign o_in_stall  = !((r_cnt == '0) || (r_cnt == CNT_W'(1) && !i_out_stall));
    assign take        = i_in_valid && !o_in_stall;

    // Next state and result list for the incoming item
    always_comb begin
        n_mode     = r_mode;
        n_held     = r_held;
        n_first    = r_first;
        n_line_inc = 1'b0;
        do_start   = 1'b0;
        n_cnt      = '0;
        for (int k = 0; k < stt_pkg::MAX_RESULTS; k++) begin
            n_res[k] = '0;
        end

        if (i_end_of_text) begin
            unique case (r_mode)
                MODE_WORD: begin
                    n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_WORD,
                                                              r_first, 1'b1);
                    n_cnt = n_cnt + CNT_W'(1);
                end
                MODE_INT, MODE_FRAC: begin
                    n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_NUMBER,
                                                              r_first, 1'b1);
                    n_cnt = n_cnt + CNT_W'(1);
                end
                MODE_SLASH: begin
                    n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_OP,
                                                              r_first, 1'b1);
                    n_cnt = n_cnt + CNT_W'(1);
                end
                MODE_OP: begin
                    if (r_held == stt_pkg::CH_BANG) begin
                        n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_warn(stt_pkg::WARN_BANG);
                    end else begin
                        n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_OP,
                                                                  r_first, 1'b1);
                    end
                    n_cnt = n_cnt + CNT_W'(1);
                end
                MODE_STR: begin
                    n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_STRING, r_first, 1'b0);
                    n_res[1] = stt_pkg::mk_tok(stt_pkg::CH_QUOTE, stt_pkg::CLS_STRING,
                                               1'b0, 1'b1);
                    n_res[2] = stt_pkg::mk_warn(stt_pkg::WARN_STR_BYTE);
                    n_cnt    = CNT_W'(3);
                end
                default: ;
            endcase
            n_mode  = MODE_IDLE;
            n_first = 1'b0;
            n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_end();
            n_cnt = n_cnt + CNT_W'(1);
        end else begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)
                        || c == stt_pkg::CH_UNDERSCORE) begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_WORD, r_first, 1'b0);
                        n_cnt    = CNT_W'(1);
                        n_held   = c;
                        n_first  = 1'b0;
                    end else begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_WORD, r_first, 1'b1);
                        n_cnt    = CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                MODE_INT, MODE_FRAC: begin
                    if (c == stt_pkg::CH_UNDERSCORE) begin
                        // underscore inside a number is dropped
                    end else if (stt_pkg::is_digit(c)) begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_NUMBER, r_first, 1'b0);
                        n_cnt    = CNT_W'(1);
                        n_held   = c;
                        n_first  = 1'b0;
                    end else if (c == stt_pkg::CH_POINT && r_mode == MODE_INT) begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_NUMBER, r_first, 1'b0);
                        n_cnt    = CNT_W'(1);
                        n_held   = c;
                        n_first  = 1'b0;
                        n_mode   = MODE_FRAC;
                    end else begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_NUMBER, r_first, 1'b1);
                        n_cnt    = CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == stt_pkg::CH_SLASH) begin
                        n_mode  = MODE_COMMENT;
                        n_first = 1'b0;
                    end else begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_OP, r_first, 1'b1);
                        n_cnt    = CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                MODE_OP: begin
                    if (c == stt_pkg::CH_EQUALS) begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_OP, r_first, 1'b0);
                        n_res[1] = stt_pkg::mk_tok(c, stt_pkg::CLS_OP, 1'b0, 1'b1);
                        n_cnt    = CNT_W'(2);
                        n_mode   = MODE_IDLE;
                        n_first  = 1'b0;
                    end else begin
                        // lone '!' becomes a warning instead of a token
                        if (r_held == stt_pkg::CH_BANG) begin
                            n_res[0] = stt_pkg::mk_warn(stt_pkg::WARN_BANG);
                        end else begin
                            n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_OP, r_first, 1'b1);
                        end
                        n_cnt    = CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (stt_pkg::str_ok(c)) begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_STRING, r_first, 1'b0);
                        n_cnt    = CNT_W'(1);
                        n_held   = c;
                        n_first  = 1'b0;
                    end else if (c == stt_pkg::CH_QUOTE) begin
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_STRING, r_first, 1'b0);
                        n_res[1] = stt_pkg::mk_tok(c, stt_pkg::CLS_STRING, 1'b0, 1'b1);
                        n_cnt    = CNT_W'(2);
                        n_mode   = MODE_IDLE;
                        n_first  = 1'b0;
                    end else begin
                        // unterminated string: add closing quote, then warn
                        n_res[0] = stt_pkg::mk_tok(r_held, stt_pkg::CLS_STRING, r_first, 1'b0);
                        n_res[1] = stt_pkg::mk_tok(stt_pkg::CH_QUOTE, stt_pkg::CLS_STRING,
                                                   1'b0, 1'b1);
                        n_cnt    = CNT_W'(3);
                        n_mode   = MODE_IDLE;
                        n_first  = 1'b0;
                        if (c == stt_pkg::CH_NEWLINE) begin
                            n_res[2]   = stt_pkg::mk_warn(stt_pkg::WARN_STR_NL);
                            n_line_inc = 1'b1;
                        end else begin
                            n_res[2] = stt_pkg::mk_warn(stt_pkg::WARN_STR_BYTE);
                            do_start = 1'b1;
                        end
                    end
                end
                MODE_COMMENT: begin
                    if (c == stt_pkg::CH_NEWLINE) begin
                        n_line_inc = 1'b1;
                        n_mode     = MODE_IDLE;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // Scan the byte afresh as the start of a new token
            if (do_start) begin
                n_mode  = MODE_IDLE;
                n_first = 1'b0;
                if (stt_pkg::is_space(c)) begin
                    if (c == stt_pkg::CH_NEWLINE) begin
                        n_line_inc = 1'b1;
                    end
                end else if (stt_pkg::is_letter(c)) begin
                    n_held = c; n_first = 1'b1; n_mode = MODE_WORD;
                end else if (stt_pkg::is_digit(c)) begin
                    n_held = c; n_first = 1'b1; n_mode = MODE_INT;
                end else if (c == stt_pkg::CH_SLASH) begin
                    n_held = c; n_first = 1'b1; n_mode = MODE_SLASH;
                end else if (stt_pkg::is_pair_op(c)) begin
                    n_held = c; n_first = 1'b1; n_mode = MODE_OP;
                end else if (c == stt_pkg::CH_QUOTE) begin
                    n_held = c; n_first = 1'b1; n_mode = MODE_STR;
                end else if (stt_pkg::is_single_op(c)) begin
                    n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_tok(c, stt_pkg::CLS_OP, 1'b1, 1'b1);
                    n_cnt = n_cnt + CNT_W'(1);
                end else begin
                    n_res[n_cnt[IDX_W-1:0]] = stt_pkg::mk_warn(stt_pkg::WARN_ILLEGAL);
                    n_cnt = n_cnt + CNT_W'(1);
                end
            end
        end
    end

    // Scanner state and line counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= '0;
            r_first <= 1'b0;
            r_line  <= stt_pkg::LINE_COUNT_BITS'(1);
        end else if (take) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_first <= n_first;
            if (n_line_inc && r_line != LINE_MAX) begin
                r_line <= r_line + stt_pkg::LINE_COUNT_BITS'(1);
            end
        end
    end

    // Result buffer count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (take) begin
            r_cnt <= n_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Result buffer payload: load on accept, shift down on each delivered item
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res      <= n_res;
            r_out_line <= r_line;
        end else if (pop) begin
            for (int k = 0; k < stt_pkg::MAX_RESULTS - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

    // Output port
    assign o_out_valid      = (r_cnt != '0);
    assign o_result_kind    = r_res[0].kind;
    assign o_token_char     = r_res[0].ch;
    assign o_token_class    = r_res[0].cls;
    assign o_first_of_token = r_res[0].first;
    assign o_last_of_token  = r_res[0].last;
    assign o_warning_code   = r_res[0].warn;
    assign o_line_number    = r_out_line;
    assign o_last_result    = (r_cnt == CNT_W'(1));

endmodule
